// ===== rtl/ip_mac_learning_table_with_aging_defines.svh =====
// Assertion macros for the checker of the binding table.
// They expect the enclosing module to have ports i_clk and i_rst_n.
`ifndef IP_MAC_LEARNING_TABLE_WITH_AGING_DEFINES_SVH
`define IP_MAC_LEARNING_TABLE_WITH_AGING_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMLT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/imlt_pkg.sv =====
package imlt_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int MODE_W  = 2;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TTLI_W  = 32;
    localparam int NOW_W   = 62;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    // Lease arithmetic: clamped seconds fit in 20 bits, product in 40,
    // expiry (now plus product) in 63.
    localparam int TTL_W  = 20;
    localparam int PROD_W = 40;
    localparam int EXP_W  = 63;

    localparam logic [TTL_W-1:0] TTL_MAX_S = 20'd604800;
    localparam logic [TTL_W-1:0] US_PER_S  = 20'd1000000;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_LEARN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd3;

    // Address filters
    localparam logic [3:0] IP_MCAST_NIBBLE = 4'hE;
    localparam int         MAC_GROUP_BIT   = 40;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TTLI_W-1:0] lease_s;
        logic [NOW_W-1:0]  now_us;
    } t_in;

    typedef struct packed {
        logic               found;
        logic [MAC_W-1:0]   found_mac;
        logic               accepted;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] entry_count;
    } t_out;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [EXP_W-1:0] expiry;
    } t_entry;

    // RAM write port
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_ram_wr;

    // Finished result offered by the engine
    typedef struct packed {
        logic done;
        t_out data;
    } t_res_if;

    function automatic logic ip_usable(logic [IP_W-1:0] ip);
        return (ip != '0) && (ip != '1) && (ip[IP_W-1 -: 4] != IP_MCAST_NIBBLE);
    endfunction

    function automatic logic mac_usable(logic [MAC_W-1:0] mac);
        return (mac != '0) && !mac[MAC_GROUP_BIT];
    endfunction

endpackage

// ===== rtl/ip_mac_learning_table_with_aging.sv =====
// IPv4-to-MAC binding table with lease expiry, ENTRIES slots (16). One request
// is in work at a time; the input stalls from the cycle after acceptance until
// the result is handed to the output register. Learn, lookup and count walk
// the entry RAM through its single read port, one entry per cycle; a clear
// or a rejected learn does not walk it and goes straight to the result.
// A lookup hit or a learn match ends the walk early. The output register
// holds one finished result, so a new request is taken while it waits.
module ip_mac_learning_table_with_aging (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  imlt_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output imlt_pkg::t_out o_out
);

    logic                              idle;
    logic                              take;
    imlt_pkg::t_res_if                 res;
    imlt_pkg::t_ram_wr                 ram_wr;
    logic [imlt_pkg::IDX_W-1:0]        ram_raddr;
    imlt_pkg::t_entry                  ram_rdata;
    logic                              r_out_valid;
    imlt_pkg::t_out                    r_out;

    imlt_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_in_valid && idle),
        .i_req    (i_in),
        .o_idle   (idle),
        .o_res    (res),
        .i_take   (take),
        .o_ram_wr (ram_wr),
        .o_raddr  (ram_raddr),
        .i_rdata  (ram_rdata)
    );

    imlt_ram #(
        .DEPTH  (imlt_pkg::ENTRIES),
        .ADDR_W (imlt_pkg::IDX_W),
        .DATA_W ($bits(imlt_pkg::t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = !idle;

    // Output register: loads when empty or being drained
    assign take = res.done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_out <= res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/imlt_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module imlt_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/imlt_engine.sv =====
// Request sequencer: walks the entry RAM one entry per cycle, keeps the
// valid bits, and writes back the chosen entry on learn.
module imlt_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  imlt_pkg::t_in                        i_req,
    output logic                                 o_idle,
    output imlt_pkg::t_res_if                    o_res,
    input  logic                                 i_take,
    output imlt_pkg::t_ram_wr                    o_ram_wr,
    output logic [imlt_pkg::IDX_W-1:0]           o_raddr,
    input  imlt_pkg::t_entry                     i_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } t_state;

    localparam logic [imlt_pkg::IDX_W-1:0] LAST_IDX =
        imlt_pkg::IDX_W'(imlt_pkg::ENTRIES - 1);

    t_state                              r_state, n_state;
    imlt_pkg::t_in                       r_req, n_req;
    logic [imlt_pkg::PROD_W-1:0]         r_prod, n_prod;
    logic [imlt_pkg::EXP_W-1:0]          r_expiry, n_expiry;
    logic [imlt_pkg::IDX_W-1:0]          r_idx, n_idx;
    logic                                r_have, n_have;
    logic [imlt_pkg::IDX_W-1:0]          r_pick, n_pick;
    logic [imlt_pkg::IDX_W-1:0]          r_oldest, n_oldest;
    logic [imlt_pkg::EXP_W-1:0]          r_oldest_exp, n_oldest_exp;
    logic [imlt_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic [imlt_pkg::ENTRIES-1:0]        r_valid, n_valid;
    imlt_pkg::t_out                      r_res, n_res;

    logic                                e_valid;
    logic                                e_ip_hit;
    logic                                e_mac_hit;
    logic                                e_expired;
    logic                                last;
    logic [imlt_pkg::TTL_W-1:0]          ttl_clamp;

    // Entry under evaluation: RAM data arrived for r_idx this cycle
    assign e_valid   = r_valid[r_idx];
    assign e_ip_hit  = (i_rdata.ip == r_req.ip);
    assign e_mac_hit = (i_rdata.mac == r_req.mac);
    assign e_expired = (i_rdata.expiry <= imlt_pkg::EXP_W'(r_req.now_us));
    assign last      = (r_idx == LAST_IDX);

    // Lease clamped to one week
    assign ttl_clamp = (i_req.lease_s > imlt_pkg::TTLI_W'(imlt_pkg::TTL_MAX_S)) ?
                       imlt_pkg::TTL_MAX_S : i_req.lease_s[imlt_pkg::TTL_W-1:0];

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_prod       = r_prod;
        n_expiry     = r_expiry;
        n_idx        = r_idx;
        n_have       = r_have;
        n_pick       = r_pick;
        n_oldest     = r_oldest;
        n_oldest_exp = r_oldest_exp;
        n_cnt        = r_cnt;
        n_valid      = r_valid;
        n_res        = r_res;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req        = i_req;
                    n_prod       = imlt_pkg::PROD_W'(ttl_clamp) *
                                   imlt_pkg::PROD_W'(imlt_pkg::US_PER_S);
                    n_idx        = '0;
                    n_have       = 1'b0;
                    n_pick       = '0;
                    n_oldest     = '0;
                    n_oldest_exp = '1;
                    n_cnt        = '0;
                    n_res        = '0;
                    case (i_req.mode)
                        imlt_pkg::MODE_CLEAR: begin
                            n_valid = '0;
                            n_state = ST_FINISH;
                        end
                        imlt_pkg::MODE_LEARN: begin
                            if (imlt_pkg::ip_usable(i_req.ip) &&
                                imlt_pkg::mac_usable(i_req.mac)) begin
                                n_state = ST_SCAN;
                            end else begin
                                n_state = ST_FINISH;
                            end
                        end
                        default: begin
                            n_state = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                n_expiry = imlt_pkg::EXP_W'(r_req.now_us) + imlt_pkg::EXP_W'(r_prod);
                n_idx    = last ? r_idx : r_idx + imlt_pkg::IDX_W'(1);
                case (r_req.mode)
                    imlt_pkg::MODE_LEARN: begin
                        if (e_valid && (e_ip_hit || e_mac_hit)) begin
                            // existing binding for this ip or mac is refreshed
                            n_pick  = r_idx;
                            n_state = ST_WRITE;
                        end else begin
                            if (!r_have && (!e_valid || e_expired)) begin
                                n_have = 1'b1;
                                n_pick = r_idx;
                            end
                            if (e_valid && (i_rdata.expiry < r_oldest_exp)) begin
                                n_oldest     = r_idx;
                                n_oldest_exp = i_rdata.expiry;
                            end
                            if (last) begin
                                if (!n_have) begin
                                    n_pick = n_oldest;
                                end
                                n_state = ST_WRITE;
                            end
                        end
                    end
                    imlt_pkg::MODE_LOOKUP: begin
                        // expired entries are retired up to the first hit
                        if (e_valid && e_expired) begin
                            n_valid[r_idx] = 1'b0;
                        end
                        if (e_valid && !e_expired && e_ip_hit) begin
                            n_res.found     = 1'b1;
                            n_res.found_mac = i_rdata.mac;
                            n_res.slot      = imlt_pkg::SLOT_W'(r_idx);
                            n_state         = ST_FINISH;
                        end else if (last) begin
                            n_state = ST_FINISH;
                        end
                    end
                    default: begin
                        // count live entries
                        if (e_valid && !e_expired) begin
                            n_cnt = r_cnt + imlt_pkg::CNT_W'(1);
                        end
                        if (last) begin
                            n_res.entry_count = imlt_pkg::COUNT_W'(n_cnt);
                            n_state           = ST_FINISH;
                        end
                    end
                endcase
            end

            ST_WRITE: begin
                n_valid[r_pick] = 1'b1;
                n_res.accepted  = 1'b1;
                n_res.slot      = imlt_pkg::SLOT_W'(r_pick);
                n_state         = ST_FINISH;
            end

            ST_FINISH: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, valid bits and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_req        <= n_req;
        r_prod       <= n_prod;
        r_expiry     <= n_expiry;
        r_idx        <= n_idx;
        r_have       <= n_have;
        r_pick       <= n_pick;
        r_oldest     <= n_oldest;
        r_oldest_exp <= n_oldest_exp;
        r_cnt        <= n_cnt;
        r_res        <= n_res;
    end

    // Read the next entry while the current one is evaluated
    assign o_raddr = ((r_state == ST_SCAN) && !last) ? r_idx + imlt_pkg::IDX_W'(1) : '0;

    // Write-back of the learned entry
    assign o_ram_wr.we          = (r_state == ST_WRITE);
    assign o_ram_wr.addr        = r_pick;
    assign o_ram_wr.data.ip     = r_req.ip;
    assign o_ram_wr.data.mac    = r_req.mac;
    assign o_ram_wr.data.expiry = r_expiry;

    assign o_idle     = (r_state == ST_IDLE);
    assign o_res.done = (r_state == ST_FINISH);
    assign o_res.data = r_res;

endmodule

// ===== rtl/imlt_checker.sv =====
`include "ip_mac_learning_table_with_aging_defines.svh"

// Port-level checks for the binding table.
module imlt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input imlt_pkg::t_out o_out
);

    // one request at a time: an accepted request closes the input
    `IMLT_ASSERT_NEXT(a_accept_stall, i_in_valid && !o_in_stall, o_in_stall, "not stalled")

    // a miss reports no MAC
    `IMLT_ASSERT_SAME(a_miss_mac, o_out_valid && !o_out.found, o_out.found_mac == '0, "miss MAC")

    // a lookup hit does not report a learn
    `IMLT_ASSERT_SAME(a_hit_alone, o_out_valid && o_out.found, !o_out.accepted, "hit and accept")

    // a held result stays offered
    `IMLT_ASSERT_NEXT(a_hold_valid, o_out_valid && i_out_stall, o_out_valid, "result dropped")

    // a held result does not change
    `IMLT_ASSERT_NEXT(a_hold_data, o_out_valid && i_out_stall, $stable(o_out), "result changed")

endmodule

bind ip_mac_learning_table_with_aging imlt_checker u_imlt_checker (.*);
